// ===== design/hcbp_pkg.sv =====
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CODE_BITS = 32;
  localparam int unsigned LEN_BITS = 6;
  localparam int unsigned PEND_BITS = 7;
  localparam int unsigned CNT_BITS = 3;
  localparam int unsigned ACC_BITS = 40;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // Command handed from the lookup front to the packing back end.
  typedef struct packed {
    logic                 is_flush;
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== design/hcbp_ifs.sv =====
// Valid/ready channel interfaces for the input items and the packed bytes.
interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  symbol;
  logic [31:0] code;
  logic [5:0]  code_length;

  modport source (output valid, output op, output symbol, output code,
                  output code_length, input ready);
  modport sink (input valid, input op, input symbol, input code,
                input code_length, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] pad_bits;
  logic       last;

  modport source (output valid, output out_byte, output pad_bits, output last,
                  input ready);
  modport sink (input valid, input out_byte, input pad_bits, input last,
                output ready);
endinterface

// ===== design/hcbp_front.sv =====
// Front end: accepts items, maintains the code table and issues pack commands.
module hcbp_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  hcbp_in_if.sink           in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output hcbp_pkg::cmd_t    push_cmd
);

  localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IDX_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              s1_valid_r;
  logic              s1_flush_r;

  logic              accept;
  logic              sym_ok;
  logic              do_load;
  logic              do_encode;
  logic              do_flush;
  logic              s1_free;
  logic [IDX_W-1:0]  idx;
  logic [5:0]        len_sat;
  logic [32:0]       mask;
  logic [31:0]       code_m;

  assign idx       = in_ch.symbol[IDX_W-1:0];
  assign sym_ok    = ({1'b0, in_ch.symbol} < 9'(SYMBOL_COUNT));
  assign accept    = in_ch.valid && in_ch.ready;
  assign do_load   = accept && (in_ch.op == hcbp_pkg::OP_LOAD) && sym_ok;
  assign do_encode = accept && (in_ch.op == hcbp_pkg::OP_ENCODE) && sym_ok;
  assign do_flush  = accept && (in_ch.op == hcbp_pkg::OP_FLUSH);

  // Lengths beyond the table width saturate; code bits above the length drop.
  assign len_sat = (in_ch.code_length > 6'(CODE_W)) ? 6'(CODE_W) : in_ch.code_length;
  assign mask    = (33'd1 << len_sat) - 33'd1;
  assign code_m  = in_ch.code & mask[31:0];

  // An encode whose entry has length zero produces nothing and is dropped here.
  assign push_valid = s1_valid_r && (s1_flush_r || (rd_len_r != '0));
  assign s1_free    = !push_valid || push_ready;
  assign in_ch.ready = !s1_valid_r || s1_free;

  assign push_cmd.is_flush = s1_flush_r;
  assign push_cmd.code     = 32'(rd_code_r);
  assign push_cmd.len      = 6'(rd_len_r);

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= code_m[CODE_W-1:0];
      len_mem[idx]  <= len_sat[LEN_W-1:0];
    end
    if (do_encode) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= do_encode || do_flush;
      s1_flush_r <= do_flush;
    end
  end

endmodule

// ===== design/hcbp_queue.sv =====
// Two-entry command queue between the front end and the packing back end.
module hcbp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  hcbp_pkg::cmd_t    push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output hcbp_pkg::cmd_t    pop_cmd
);

  hcbp_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/hcbp_back.sv =====
// Back end: appends codes to the bit accumulator and emits packed bytes.
module hcbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  hcbp_pkg::cmd_t    pop_cmd,
  hcbp_out_if.source        out_ch
);

  localparam int ACC_W = hcbp_pkg::ACC_BITS;

  hcbp_pkg::bk_state_t state_r, state_nxt;

  // Pending bits are kept left aligned; unused low bits stay zero.
  logic [6:0]       pend_r, pend_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [ACC_W-1:0] word_r, word_nxt;
  logic [2:0]       rem_r, rem_nxt;
  logic [2:0]       tail_r, tail_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [2:0]       pad_r, pad_nxt;
  logic             last_r, last_nxt;

  logic             out_take;
  logic [31:0]      code_al;
  logic [ACC_W-1:0] word_new;
  logic [5:0]       total;

  assign out_take = !out_valid_r || out_ch.ready;
  assign code_al  = pop_cmd.code << (6'd32 - pop_cmd.len);
  assign word_new = {pend_r, 33'd0} | ({code_al, 8'd0} >> cnt_r);
  assign total    = 6'(cnt_r) + pop_cmd.len;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.pad_bits = pad_r;
  assign out_ch.last     = last_r;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    rem_nxt       = rem_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    pad_nxt       = pad_r;
    last_nxt      = last_r;
    pop_ready     = 1'b0;
    unique case (state_r)
      hcbp_pkg::BK_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.is_flush) begin
            if (cnt_r == 3'd0) begin
              pop_ready = 1'b1;
            end else if (out_take) begin
              pop_ready     = 1'b1;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = {pend_r, 1'b0};
              pad_nxt       = 3'(4'd8 - {1'b0, cnt_r});
              last_nxt      = 1'b1;
              pend_nxt      = '0;
              cnt_nxt       = '0;
            end
          end else begin
            pop_ready = 1'b1;
            if (total[5:3] == 3'd0) begin
              pend_nxt = word_new[ACC_W-1 -: 7];
              cnt_nxt  = total[2:0];
            end else begin
              word_nxt  = word_new;
              rem_nxt   = total[5:3];
              tail_nxt  = total[2:0];
              state_nxt = hcbp_pkg::BK_EMIT;
            end
          end
        end
      end
      hcbp_pkg::BK_EMIT: begin
        if (out_take) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = word_r[ACC_W-1 -: 8];
          pad_nxt       = '0;
          last_nxt      = (rem_r == 3'd1);
          word_nxt      = word_r << 8;
          rem_nxt       = rem_r - 3'd1;
          if (rem_r == 3'd1) begin
            pend_nxt  = word_r[ACC_W-9 -: 7];
            cnt_nxt   = tail_r;
            state_nxt = hcbp_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = hcbp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcbp_pkg::BK_IDLE;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    rem_r      <= rem_nxt;
    tail_r     <= tail_nxt;
    out_byte_r <= out_byte_nxt;
    pad_r      <= pad_nxt;
    last_r     <= last_nxt;
  end

endmodule

// ===== design/huffman_code_bit_packer_unit.sv =====
// Top level of the Huffman code bit packer: front end, command queue, back end.
//
// Usage: items arrive as beats on in_ch (valid/ready). A load beat writes one
// symbol's code and length into the code table; an encode beat looks the
// symbol up and appends its code, first bit first, to the bit accumulator;
// a flush beat emits the partial byte padded with zeros at the low end.
// Packed bytes leave as beats on out_ch, one per cycle at most, with last
// set on the final byte that an item produces and pad_bits nonzero on flush.
// An encode that completes a byte passes the table read register, the queue,
// the back end's word register and the output register before that byte is
// on out_ch; later bytes follow one a cycle while out_ch is ready. The back
// end takes no new command until every byte of an encode has left, and loads
// never reach it. The front end keeps accepting beats while the two-entry
// queue has room, even while out_ch is stalled.
// Reset clears the accumulator, the queue and all handshake state; the code
// table is not cleared, and entries must be loaded before they are encoded.
// When the receiver holds out_ready low, the current byte stays on out_ch,
// the back end stops, the queue fills and then in_ch ready drops.
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);

  // Commands that survived classification in the front end.
  logic           push_valid;
  logic           push_ready;
  hcbp_pkg::cmd_t push_cmd;

  // Commands leaving the queue toward the packer.
  logic           pop_valid;
  logic           pop_ready;
  hcbp_pkg::cmd_t pop_cmd;

  // The front end owns the code table and drops items that emit nothing
  // regardless of accumulator state (loads, unused op codes, symbols beyond
  // the table, zero-length codes).
  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // The queue lets the front end run ahead while bytes are being emitted.
  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // The back end holds the pending bits and drives the output register.
  hcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Huffman code bit packer top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Op code 3 has no member in op_t; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // With the default MAX_CODE_LEN of 32 a loaded length saturates at the code width.
  localparam int unsigned LEN_CAP = hcbp_pkg::CODE_BITS;

  // One packed byte as it leaves on out_ch.
  typedef struct packed {
    logic [hcbp_pkg::BYTE_BITS-1:0] data;
    logic [hcbp_pkg::CNT_BITS-1:0]  pad;
    logic                           last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hcbp_in_if  in_ch();
  hcbp_out_if out_ch();

  huffman_code_bit_packer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns period, rising edge at 6 ns.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the code table and the bit accumulator.
  logic [hcbp_pkg::CODE_BITS-1:0] code_table [256];
  logic [hcbp_pkg::LEN_BITS-1:0]  len_table [256];
  logic [7:0]                     loaded_syms [$];
  bit                             sym_loaded [256];
  logic [hcbp_pkg::PEND_BITS-1:0] pend_bits;
  logic [hcbp_pkg::CNT_BITS-1:0]  pend_cnt;

  // Bytes predicted but not yet seen on out_ch, oldest first.
  packed_byte_t byte_queue [$];

  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Updates the table and accumulator for one accepted beat and queues the
  // bytes that beat must produce. Called right at the accepting edge.
  function automatic void predict_item(logic [1:0] op, logic [7:0] sym,
                                       logic [hcbp_pkg::CODE_BITS-1:0] code,
                                       logic [hcbp_pkg::LEN_BITS-1:0] len_in);
    logic [hcbp_pkg::ACC_BITS-1:0] acc;
    int unsigned len;
    int unsigned total;
    packed_byte_t pb;
    unique case (op)
      hcbp_pkg::OP_LOAD: begin
        // An overlong length saturates, and code bits above the length drop.
        len = (len_in > LEN_CAP) ? LEN_CAP : len_in;
        code_table[sym] = code & hcbp_pkg::CODE_BITS'((64'd1 << len) - 64'd1);
        len_table[sym] = hcbp_pkg::LEN_BITS'(len);
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
      end
      hcbp_pkg::OP_ENCODE: begin
        len = len_table[sym];
        // A zero-length code adds nothing and emits nothing.
        if (len == 0) return;
        acc = (hcbp_pkg::ACC_BITS'(pend_bits) << len) |
              hcbp_pkg::ACC_BITS'(code_table[sym]);
        total = pend_cnt + len;
        // At most 7 pending plus 32 new bits, so never more than four bytes.
        while (total >= hcbp_pkg::BYTE_BITS) begin
          total -= hcbp_pkg::BYTE_BITS;
          pb.data = hcbp_pkg::BYTE_BITS'(acc >> total);
          pb.pad = '0;
          pb.last = (total < hcbp_pkg::BYTE_BITS);
          byte_queue.push_back(pb);
        end
        pend_cnt = hcbp_pkg::CNT_BITS'(total);
        pend_bits = hcbp_pkg::PEND_BITS'(acc & ((hcbp_pkg::ACC_BITS'(1) << total) -
                                                hcbp_pkg::ACC_BITS'(1)));
      end
      hcbp_pkg::OP_FLUSH: begin
        // A flush with nothing pending is silent.
        if (pend_cnt != 0) begin
          pb.data = hcbp_pkg::BYTE_BITS'(pend_bits) << (hcbp_pkg::BYTE_BITS - pend_cnt);
          pb.pad = hcbp_pkg::CNT_BITS'(hcbp_pkg::BYTE_BITS - pend_cnt);
          pb.last = 1'b1;
          byte_queue.push_back(pb);
          pend_bits = '0;
          pend_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Sends one beat. Inputs move only at the falling edge; valid stays high
  // between back-to-back beats and drops for each cycle the sender idles, so
  // a step never carries two assignments to valid.
  task automatic send_item(logic [1:0] op, logic [7:0] sym,
                           logic [hcbp_pkg::CODE_BITS-1:0] code,
                           logic [hcbp_pkg::LEN_BITS-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.symbol      <= sym;
    in_ch.code        <= code;
    in_ch.code_length <= len;
    // Ready is read at the rising edge before any update of that edge lands.
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, sym, code, len);
  endtask

  // Encode and flush beats carry random junk in the fields they do not use.
  task automatic encode_symbol(logic [7:0] sym);
    send_item(hcbp_pkg::OP_ENCODE, sym, $urandom(), hcbp_pkg::LEN_BITS'($urandom()));
  endtask

  task automatic flush_bits();
    send_item(hcbp_pkg::OP_FLUSH, 8'($urandom()), $urandom(),
              hcbp_pkg::LEN_BITS'($urandom()));
  endtask

  // Mostly short codes so flushes find partial bytes, with some long ones,
  // some of length zero and some above the cap.
  function automatic logic [hcbp_pkg::LEN_BITS-1:0] random_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 15) return hcbp_pkg::LEN_BITS'($urandom_range(63, LEN_CAP + 1));
    if (pick < 35) return hcbp_pkg::LEN_BITS'($urandom_range(LEN_CAP, 17));
    return hcbp_pkg::LEN_BITS'($urandom_range(16, 1));
  endfunction

  // The receiver drops ready at random at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted byte must match the oldest prediction in all fields.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (byte_queue.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected byte: expected none,", $time,
                 " actual data=%02h pad=%0d last=%0b",
                 out_ch.out_byte, out_ch.pad_bits, out_ch.last);
      end else begin
        want = byte_queue.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.pad_bits !== want.pad ||
            out_ch.last !== want.last) begin
          fail_count++;
          $display("%0t: byte differs: expected data=%02h pad=%0d last=%0b,",
                   $time, want.data, want.pad, want.last,
                   " actual data=%02h pad=%0d last=%0b",
                   out_ch.out_byte, out_ch.pad_bits, out_ch.last);
        end
      end
    end
  end

  // Flush on an empty accumulator and the unused op, which must stay silent.
  task automatic test_empty_flush_and_unused_op();
    flush_bits();
    send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_item(OP_UNUSED, 8'($urandom()), $urandom(), hcbp_pkg::LEN_BITS'($urandom()));
  endtask

  // Table loads at the edges: zero length, full length, a length above the
  // cap, and codes with bits set above their length.
  task automatic test_table_edges();
    send_item(hcbp_pkg::OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    encode_symbol(8'd0);
    send_item(hcbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_item(hcbp_pkg::OP_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd63);
    send_item(hcbp_pkg::OP_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd3);
    send_item(hcbp_pkg::OP_LOAD, 8'd5, 32'h0000_00A5, 6'd8);
    send_item(hcbp_pkg::OP_LOAD, 8'd4, 32'h0000_0000, 6'd32);
    send_item(hcbp_pkg::OP_LOAD, 8'd128, 32'h1234_5678, 6'd33);
  endtask

  // Long codes on top of pending bits give four bytes from one beat; the
  // flushes check the padding and the empty case right after one.
  task automatic test_long_codes();
    encode_symbol(8'd2);
    encode_symbol(8'd255);
    encode_symbol(8'd1);
    flush_bits();
    encode_symbol(8'd255);
    encode_symbol(8'd5);
    encode_symbol(8'd4);
    encode_symbol(8'd128);
    encode_symbol(8'd2);
    flush_bits();
    flush_bits();
  endtask

  // Random stream: mostly encodes of loaded symbols, with reloads, flushes
  // and the odd ignored beat. Ignored beats do not count toward the total.
  task automatic test_random_stream(int unsigned items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(OP_UNUSED, 8'($urandom()), $urandom(),
                  hcbp_pkg::LEN_BITS'($urandom()));
      end else begin
        if (pick < 20 || loaded_syms.size() == 0)
          send_item(hcbp_pkg::OP_LOAD, 8'($urandom()), $urandom(), random_length());
        else if (pick < 32)
          flush_bits();
        else
          encode_symbol(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    in_ch.valid       = 1'b0;
    in_ch.op          = hcbp_pkg::OP_LOAD;
    in_ch.symbol      = '0;
    in_ch.code        = '0;
    in_ch.code_length = '0;
    out_ch.ready      = 1'b0;
    pend_bits         = '0;
    pend_cnt          = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_flush_and_unused_op();
    test_table_edges();
    test_long_codes();

    // Light sender gaps against a mostly stalled receiver, then the reverse,
    // then full rate on both sides.
    send_idle_pct = 10;
    recv_idle_pct = 78;
    test_random_stream(115);
    send_idle_pct = 78;
    recv_idle_pct = 10;
    test_random_stream(115);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(115);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain, then keep the pipeline running a while longer to show any extra byte.
    waited = 0;
    while (byte_queue.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (byte_queue.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected bytes never arrived,", $time, byte_queue.size(),
               " expected data=%02h pad=%0d last=%0b, actual none",
               byte_queue[0].data, byte_queue[0].pad, byte_queue[0].last);
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
